/* hdl/dir_entry_stream_parser_top_defines.svh */
// ----------------------------------------------------------------------------
// Directory entry stream parser: assertion macros
// Shared property forms for the checker. Each macro expects clk and rst_n in
// scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef DIR_ENTRY_STREAM_PARSER_TOP_DEFINES_SVH
`define DIR_ENTRY_STREAM_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dep_pkg.sv */
// ----------------------------------------------------------------------------
// Directory entry stream parser package
// Field phases, result kinds, field lengths and the structs passed between
// the parser core, the result queue and the top level.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int SCORE_BYTES = 20;

    localparam logic [15:0] LEN_TAG   = 16'd1;
    localparam logic [15:0] LEN_HALF  = 16'd2;
    localparam logic [15:0] LEN_WORD  = 16'd4;
    localparam logic [15:0] LEN_DWORD = 16'd8;
    localparam logic [15:0] LEN_SCORE = 16'(SCORE_BYTES);
    localparam logic [15:0] P9_OPT_LEN = 16'd12;

    localparam logic [15:0] VERSION_OLD = 16'd7;
    localparam logic [15:0] VERSION_NEW = 16'd8;

    // Configuration register indexes.
    localparam logic CFG_ENTRY_MAGIC = 1'b0;
    localparam logic CFG_EXT_TAG     = 1'b1;

    // Result queue sizing.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [22:0] {
        PH_MAGIC    = 23'h000001,
        PH_VERSION  = 23'h000002,
        PH_ELEM_LEN = 23'h000004,
        PH_ELEM_STR = 23'h000008,
        PH_ENTRY    = 23'h000010,
        PH_QID      = 23'h000020,
        PH_SCORE    = 23'h000040,
        PH_UID_LEN  = 23'h000080,
        PH_UID_STR  = 23'h000100,
        PH_GID_LEN  = 23'h000200,
        PH_GID_STR  = 23'h000400,
        PH_MID_LEN  = 23'h000800,
        PH_MID_STR  = 23'h001000,
        PH_MTIME    = 23'h002000,
        PH_MCOUNT   = 23'h004000,
        PH_CTIME    = 23'h008000,
        PH_ATIME    = 23'h010000,
        PH_MODE     = 23'h020000,
        PH_OPT_TAG  = 23'h040000,
        PH_OPT_LEN  = 23'h080000,
        PH_OPT_SKIP = 23'h100000,
        PH_P9PATH   = 23'h200000,
        PH_P9VER    = 23'h400000
    } phase_t;

    typedef enum logic [3:0] {
        KIND_VERSION   = 4'd0,
        KIND_ELEM      = 4'd1,
        KIND_ENTRY     = 4'd2,
        KIND_QID       = 4'd3,
        KIND_UID       = 4'd4,
        KIND_GID       = 4'd5,
        KIND_MID       = 4'd6,
        KIND_MTIME     = 4'd7,
        KIND_MCOUNT    = 4'd8,
        KIND_CTIME     = 4'd9,
        KIND_ATIME     = 4'd10,
        KIND_MODE      = 4'd11,
        KIND_P9PATH    = 4'd12,
        KIND_P9VERSION = 4'd13,
        KIND_OK        = 4'd14,
        KIND_ERROR     = 4'd15
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic        last;
    } result_t;

    // Results produced by one accepted word, in output order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic not_empty;
        logic has_room;
    } rq_status_t;

    typedef struct packed {
        logic [31:0] entry_magic;
        logic [7:0]  ext_tag;
    } cfg_t;

    // Number of bytes in a fixed-size field.
    function automatic logic [15:0] field_len(phase_t ph);
        logic [15:0] n;
        unique case (ph)
            PH_MAGIC, PH_ENTRY, PH_MTIME, PH_MCOUNT, PH_CTIME, PH_ATIME,
            PH_MODE, PH_P9VER:     n = LEN_WORD;
            PH_QID, PH_P9PATH:     n = LEN_DWORD;
            PH_SCORE:              n = LEN_SCORE;
            PH_OPT_TAG:            n = LEN_TAG;
            default:               n = LEN_HALF;
        endcase
        return n;
    endfunction

endpackage

/* hdl/dep_parse_core.sv */
// ----------------------------------------------------------------------------
// Directory entry stream parser: parse core
// Holds the per-entry field state and turns each accepted byte into at most
// one field result plus a status result on the final byte.
// ----------------------------------------------------------------------------
module dep_parse_core
    import dep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_entry,
    input  cfg_t       cfg,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic        ver7_reg, ver7_next;
    logic        seen_reg, seen_next;
    logic        failed_reg, failed_next;
    logic [7:0]  tag_reg, tag_next;

    logic [63:0] acc_shift;
    logic [15:0] left_dec;
    logic [15:0] len16;
    logic        done;
    logic        go_en;
    phase_t      go_ph;
    logic        str_en;
    phase_t      str_ph;
    phase_t      after_ph;
    logic        fld_valid;
    kind_t       fld_kind;
    logic [63:0] fld_value;
    logic        entry_ok;
    result_t     fld_res;
    result_t     stat_res;

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        ver7_next   = ver7_reg;
        seen_next   = seen_reg;
        failed_next = failed_reg;
        tag_next    = tag_reg;
        go_en       = 1'b0;
        go_ph       = phase_reg;
        str_en      = 1'b0;
        str_ph      = phase_reg;
        after_ph    = phase_reg;
        fld_valid   = 1'b0;
        fld_kind    = KIND_VERSION;
        fld_value   = {56'd0, data_byte};
        entry_ok    = 1'b0;

        acc_shift = {acc_reg[55:0], data_byte};
        left_dec  = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
        len16     = acc_shift[15:0];
        done      = (left_dec == 16'd0);

        if (!failed_reg)
        begin
            left_next = left_dec;
            unique case (phase_reg)
                PH_ELEM_STR:
                begin
                    fld_valid = 1'b1;
                    fld_kind  = KIND_ELEM;
                    go_en     = done;
                    go_ph     = PH_ENTRY;
                end
                PH_UID_STR:
                begin
                    fld_valid = 1'b1;
                    fld_kind  = KIND_UID;
                    go_en     = done;
                    go_ph     = PH_GID_LEN;
                end
                PH_GID_STR:
                begin
                    fld_valid = 1'b1;
                    fld_kind  = KIND_GID;
                    go_en     = done;
                    go_ph     = PH_MID_LEN;
                end
                PH_MID_STR:
                begin
                    fld_valid = 1'b1;
                    fld_kind  = KIND_MID;
                    go_en     = done;
                    go_ph     = PH_MTIME;
                end
                PH_OPT_SKIP:
                begin
                    go_en = done;
                    go_ph = PH_OPT_TAG;
                end
                PH_MAGIC:
                begin
                    acc_next = acc_shift;
                    if (done)
                    begin
                        if (acc_shift[31:0] != cfg.entry_magic)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            go_en = 1'b1;
                            go_ph = PH_VERSION;
                        end
                    end
                end
                PH_VERSION:
                begin
                    acc_next = acc_shift;
                    if (done)
                    begin
                        if (len16 == VERSION_OLD || len16 == VERSION_NEW)
                        begin
                            fld_valid = 1'b1;
                            fld_kind  = KIND_VERSION;
                            fld_value = {48'd0, len16};
                            ver7_next = (len16 == VERSION_OLD);
                            go_en     = 1'b1;
                            go_ph     = PH_ELEM_LEN;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
                PH_ELEM_LEN:
                begin
                    acc_next = acc_shift;
                    str_en   = done;
                    str_ph   = PH_ELEM_STR;
                    after_ph = PH_ENTRY;
                end
                PH_ENTRY:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_ENTRY;
                    fld_value = {32'd0, acc_shift[31:0]};
                    go_en     = done;
                    go_ph     = PH_QID;
                end
                PH_QID:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_QID;
                    fld_value = acc_shift;
                    go_en     = done;
                    go_ph     = ver7_reg ? PH_SCORE : PH_UID_LEN;
                end
                PH_SCORE:
                begin
                    acc_next = acc_shift;
                    go_en    = done;
                    go_ph    = PH_UID_LEN;
                end
                PH_UID_LEN:
                begin
                    acc_next = acc_shift;
                    str_en   = done;
                    str_ph   = PH_UID_STR;
                    after_ph = PH_GID_LEN;
                end
                PH_GID_LEN:
                begin
                    acc_next = acc_shift;
                    str_en   = done;
                    str_ph   = PH_GID_STR;
                    after_ph = PH_MID_LEN;
                end
                PH_MID_LEN:
                begin
                    acc_next = acc_shift;
                    str_en   = done;
                    str_ph   = PH_MID_STR;
                    after_ph = PH_MTIME;
                end
                PH_MTIME:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_MTIME;
                    fld_value = {32'd0, acc_shift[31:0]};
                    go_en     = done;
                    go_ph     = PH_MCOUNT;
                end
                PH_MCOUNT:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_MCOUNT;
                    fld_value = {32'd0, acc_shift[31:0]};
                    go_en     = done;
                    go_ph     = PH_CTIME;
                end
                PH_CTIME:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_CTIME;
                    fld_value = {32'd0, acc_shift[31:0]};
                    go_en     = done;
                    go_ph     = PH_ATIME;
                end
                PH_ATIME:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_ATIME;
                    fld_value = {32'd0, acc_shift[31:0]};
                    go_en     = done;
                    go_ph     = PH_MODE;
                end
                PH_MODE:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_MODE;
                    fld_value = {32'd0, acc_shift[31:0]};
                    go_en     = done;
                    go_ph     = PH_OPT_TAG;
                end
                PH_OPT_TAG:
                begin
                    acc_next = acc_shift;
                    if (done)
                    begin
                        tag_next = acc_shift[7:0];
                    end
                    go_en = done;
                    go_ph = PH_OPT_LEN;
                end
                PH_OPT_LEN:
                begin
                    acc_next = acc_shift;
                    if (done)
                    begin
                        if (tag_reg == cfg.ext_tag)
                        begin
                            if (seen_reg || len16 != P9_OPT_LEN)
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                seen_next = 1'b1;
                                go_en     = 1'b1;
                                go_ph     = PH_P9PATH;
                            end
                        end
                        else
                        begin
                            str_en   = 1'b1;
                            str_ph   = PH_OPT_SKIP;
                            after_ph = PH_OPT_TAG;
                        end
                    end
                end
                PH_P9PATH:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_P9PATH;
                    fld_value = acc_shift;
                    go_en     = done;
                    go_ph     = PH_P9VER;
                end
                PH_P9VER:
                begin
                    acc_next  = acc_shift;
                    fld_valid = done;
                    fld_kind  = KIND_P9VERSION;
                    fld_value = {32'd0, acc_shift[31:0]};
                    go_en     = done;
                    go_ph     = PH_OPT_TAG;
                end
                default:
                begin
                    acc_next = acc_shift;
                    if (done)
                    begin
                        failed_next = 1'b1;
                    end
                end
            endcase

            // A completed length either opens its string or, when empty,
            // moves straight on to the following field.
            if (str_en)
            begin
                if (len16 == 16'd0)
                begin
                    go_en = 1'b1;
                    go_ph = after_ph;
                end
                else
                begin
                    phase_next = str_ph;
                    left_next  = len16;
                    acc_next   = 64'd0;
                end
            end

            if (go_en)
            begin
                phase_next = go_ph;
                left_next  = field_len(go_ph);
                acc_next   = 64'd0;
            end
        end

        // The entry is good only if it closes on an option boundary.
        if (end_of_entry)
        begin
            entry_ok    = !failed_next && (phase_next == PH_OPT_TAG);
            phase_next  = PH_MAGIC;
            left_next   = LEN_WORD;
            acc_next    = 64'd0;
            ver7_next   = 1'b0;
            seen_next   = 1'b0;
            failed_next = 1'b0;
            tag_next    = 8'd0;
        end
    end

    always_comb
    begin
        fld_res.kind   = fld_kind;
        fld_res.value  = fld_value;
        fld_res.last   = 1'b0;
        stat_res.kind  = entry_ok ? KIND_OK : KIND_ERROR;
        stat_res.value = 64'd0;
        stat_res.last  = 1'b1;

        push.count  = accept ? ({1'b0, fld_valid} + {1'b0, end_of_entry}) : 2'd0;
        push.first  = fld_valid ? fld_res : stat_res;
        push.second = stat_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            left_reg   <= LEN_WORD;
            acc_reg    <= 64'd0;
            ver7_reg   <= 1'b0;
            seen_reg   <= 1'b0;
            failed_reg <= 1'b0;
            tag_reg    <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            acc_reg    <= acc_next;
            ver7_reg   <= ver7_next;
            seen_reg   <= seen_next;
            failed_reg <= failed_next;
            tag_reg    <= tag_next;
        end
    end

endmodule

/* hdl/dep_result_fifo.sv */
// ----------------------------------------------------------------------------
// Directory entry stream parser: result queue
// Small register queue that takes up to two results per cycle and hands out
// one per cycle, decoupling the parser from a stalled receiver.
// ----------------------------------------------------------------------------
module dep_result_fifo
    import dep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    input  logic       pop,
    output result_t    head,
    output rq_status_t status
);

    result_t               mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic [RQ_PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + RQ_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + RQ_PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + RQ_PTR_W'(pop);
    assign count_next   = count_reg + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);

    assign head             = mem_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    // Room for the two results that a final byte can produce.
    assign status.has_room  = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

/* hdl/dir_entry_stream_parser_top.sv */
// ----------------------------------------------------------------------------
// Directory entry stream parser
// Parses a byte stream of directory entries into field and status words.
//
// Input channel (in_valid/in_ready, data_byte, end_of_entry) carries one
// entry byte per word; end_of_entry marks the final byte. Output channel
// (out_valid/out_ready, kind, value, last) carries result words: version,
// string bytes, fixed fields, extension fields, and one ok or error status
// word with last set after the final byte. On error the receiver drops the
// whole entry.
// A byte's results are written into the result queue as it is accepted and
// are presented from the queue head. Throughput: one byte per cycle while
// the queue has room. The final byte can yield two result words; a
// four-entry result queue absorbs this and in_ready drops when fewer than
// two queue slots are free. When the receiver stalls, the queue fills and
// in_ready falls; no word is lost. Reset clears the parse state to the start
// of an entry, empties the queue and clears both configuration registers.
// cfg_wen writes cfg_data into register cfg_index (0 magic word, 1 extension
// tag) at once; write only while the block is idle.
// ----------------------------------------------------------------------------
module dir_entry_stream_parser_top
    import dep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_entry,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [63:0] value,
    output logic        last,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t       cfg_reg;
    push_t      push;
    result_t    head;
    rq_status_t rq_status;
    logic       accept;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_magic <= 32'd0;
            cfg_reg.ext_tag     <= 8'd0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_ENTRY_MAGIC: cfg_reg.entry_magic <= cfg_data;
                CFG_EXT_TAG:     cfg_reg.ext_tag     <= cfg_data[7:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign in_ready  = rq_status.has_room;
    assign accept    = in_valid && in_ready;
    assign out_valid = rq_status.not_empty;
    assign pop       = out_valid && out_ready;

    dep_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .end_of_entry (end_of_entry),
        .cfg          (cfg_reg),
        .push         (push)
    );

    dep_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (rq_status)
    );

    assign kind  = head.kind;
    assign value = head.value;
    assign last  = head.last;

endmodule

/* hdl/dep_checker.sv */
// ----------------------------------------------------------------------------
// Directory entry stream parser: port checker
// Watches the top level's ports for status word framing, output stability
// and queue back-pressure consistency.
// ----------------------------------------------------------------------------
`include "dir_entry_stream_parser_top_defines.svh"

module dep_checker
    import dep_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  kind,
    input logic [63:0] value,
    input logic        last
);

    `DEP_ASSERT_SAME(a_last_is_status, out_valid && last, kind == KIND_OK || kind == KIND_ERROR, "last set on a non-status word")
    `DEP_ASSERT_SAME(a_status_framing, out_valid && (kind == KIND_OK || kind == KIND_ERROR), last && value == 64'd0, "status word without last or with nonzero value")
    `DEP_ASSERT_SAME(a_backpressure_has_data, !in_ready, out_valid, "input stalled while no result is pending")
    `DEP_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(kind) && $stable(value) && $stable(last), "stalled output word changed")

endmodule

bind dir_entry_stream_parser_top dep_checker u_dep_checker (.*);

/* tb/dir_entry_stream_parser_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory entry stream parser testbench
// Builds directory entries byte by byte, well-formed and broken, and sends them
// through the parser with random gaps on both channels. A scoreboard decodes
// every accepted byte on its own and checks each result word in order.
// ----------------------------------------------------------------------------
import dep_pkg::*;

class EntryFieldScoreboard;
    result_t     expected_words[$];
    int          errors;
    logic [31:0] magic_reg;
    logic [7:0]  ext_tag_reg;
    phase_t      ph;
    logic [15:0] remaining;
    logic [63:0] acc;
    bit          v7;
    bit          ext_seen;
    bit          broken;
    logic [7:0]  opt_tag;

    function new();
        errors = 0;
        magic_reg = '0;
        ext_tag_reg = '0;
        restart();
    endfunction

    function void set_regs(logic [31:0] magic, logic [7:0] tag);
        magic_reg = magic;
        ext_tag_reg = tag;
    endfunction

    function int waiting();
        return expected_words.size();
    endfunction

    function int span(phase_t p);
        case (p)
            PH_QID, PH_P9PATH: return 8;
            PH_SCORE:          return SCORE_BYTES;
            PH_OPT_TAG:        return 1;
            PH_MAGIC, PH_ENTRY, PH_MTIME, PH_MCOUNT, PH_CTIME, PH_ATIME,
            PH_MODE, PH_P9VER: return 4;
            default:           return 2;
        endcase
    endfunction

    function void enter(phase_t p);
        ph = p;
        remaining = 16'(span(p));
        acc = '0;
    endfunction

    function void restart();
        enter(PH_MAGIC);
        v7 = 1'b0;
        ext_seen = 1'b0;
        broken = 1'b0;
        opt_tag = '0;
    endfunction

    // A zero length goes straight on to the field after the string.
    function void open_string(phase_t str_ph, phase_t after);
        if (acc[15:0] == 16'd0)
            enter(after);
        else
        begin
            ph = str_ph;
            remaining = acc[15:0];
            acc = '0;
        end
    endfunction

    function void push(kind_t k, logic [63:0] v, logic l);
        result_t r;
        r.kind = k;
        r.value = v;
        r.last = l;
        expected_words.push_back(r);
    endfunction

    function void consume(logic [7:0] b);
        if (ph inside {PH_ELEM_STR, PH_UID_STR, PH_GID_STR, PH_MID_STR, PH_OPT_SKIP})
        begin
            case (ph)
                PH_ELEM_STR: push(KIND_ELEM, {56'd0, b}, 1'b0);
                PH_UID_STR:  push(KIND_UID, {56'd0, b}, 1'b0);
                PH_GID_STR:  push(KIND_GID, {56'd0, b}, 1'b0);
                PH_MID_STR:  push(KIND_MID, {56'd0, b}, 1'b0);
                default:     ;
            endcase
            if (remaining != 16'd0)
                remaining--;
            if (remaining == 16'd0)
            begin
                case (ph)
                    PH_ELEM_STR: enter(PH_ENTRY);
                    PH_UID_STR:  enter(PH_GID_LEN);
                    PH_GID_STR:  enter(PH_MID_LEN);
                    PH_MID_STR:  enter(PH_MTIME);
                    default:     enter(PH_OPT_TAG);
                endcase
            end
            return;
        end
        acc = {acc[55:0], b};
        if (remaining != 16'd0)
            remaining--;
        if (remaining != 16'd0)
            return;
        case (ph)
            PH_MAGIC:
                if (acc[31:0] != magic_reg)
                    broken = 1'b1;
                else
                    enter(PH_VERSION);
            PH_VERSION:
                if (acc[15:0] != VERSION_OLD && acc[15:0] != VERSION_NEW)
                    broken = 1'b1;
                else
                begin
                    push(KIND_VERSION, {48'd0, acc[15:0]}, 1'b0);
                    v7 = (acc[15:0] == VERSION_OLD);
                    enter(PH_ELEM_LEN);
                end
            PH_ELEM_LEN: open_string(PH_ELEM_STR, PH_ENTRY);
            PH_ENTRY:
            begin
                push(KIND_ENTRY, {32'd0, acc[31:0]}, 1'b0);
                enter(PH_QID);
            end
            PH_QID:
            begin
                push(KIND_QID, acc, 1'b0);
                enter(v7 ? PH_SCORE : PH_UID_LEN);
            end
            PH_SCORE:   enter(PH_UID_LEN);
            PH_UID_LEN: open_string(PH_UID_STR, PH_GID_LEN);
            PH_GID_LEN: open_string(PH_GID_STR, PH_MID_LEN);
            PH_MID_LEN: open_string(PH_MID_STR, PH_MTIME);
            PH_MTIME:
            begin
                push(KIND_MTIME, {32'd0, acc[31:0]}, 1'b0);
                enter(PH_MCOUNT);
            end
            PH_MCOUNT:
            begin
                push(KIND_MCOUNT, {32'd0, acc[31:0]}, 1'b0);
                enter(PH_CTIME);
            end
            PH_CTIME:
            begin
                push(KIND_CTIME, {32'd0, acc[31:0]}, 1'b0);
                enter(PH_ATIME);
            end
            PH_ATIME:
            begin
                push(KIND_ATIME, {32'd0, acc[31:0]}, 1'b0);
                enter(PH_MODE);
            end
            PH_MODE:
            begin
                push(KIND_MODE, {32'd0, acc[31:0]}, 1'b0);
                enter(PH_OPT_TAG);
            end
            PH_OPT_TAG:
            begin
                opt_tag = acc[7:0];
                enter(PH_OPT_LEN);
            end
            PH_OPT_LEN:
                if (opt_tag == ext_tag_reg)
                begin
                    if (ext_seen || acc[15:0] != P9_OPT_LEN)
                        broken = 1'b1;
                    else
                    begin
                        ext_seen = 1'b1;
                        enter(PH_P9PATH);
                    end
                end
                else
                    open_string(PH_OPT_SKIP, PH_OPT_TAG);
            PH_P9PATH:
            begin
                push(KIND_P9PATH, acc, 1'b0);
                enter(PH_P9VER);
            end
            PH_P9VER:
            begin
                push(KIND_P9VERSION, {32'd0, acc[31:0]}, 1'b0);
                enter(PH_OPT_TAG);
            end
            default: broken = 1'b1;
        endcase
    endfunction

    // Bytes after a failure are dropped until the final byte of the entry.
    function void note_byte(logic [7:0] b, logic eoe);
        if (!broken)
            consume(b);
        if (eoe)
        begin
            if (!broken && ph == PH_OPT_TAG)
                push(KIND_OK, 64'd0, 1'b1);
            else
                push(KIND_ERROR, 64'd0, 1'b1);
            restart();
        end
    endfunction

    function void check_word(logic [3:0] k, logic [63:0] v, logic l);
        result_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected word: kind %0d value %h last %b", $time, k, v, l);
            errors++;
            return;
        end
        want = expected_words.pop_front();
        if (k !== want.kind)
        begin
            $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, k);
            errors++;
        end
        if (v !== want.value)
        begin
            $display("%0t: value mismatch: expected %h, got %h", $time, want.value, v);
            errors++;
        end
        if (l !== want.last)
        begin
            $display("%0t: last mismatch: expected %b, got %b", $time, want.last, l);
            errors++;
        end
    endfunction
endclass

module dir_entry_stream_parser_top_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_BYTES = 1000;
    localparam int PHASES = 4;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        int          elem_len;
        int          uid_len;
        int          gid_len;
        int          mid_len;
        bit          huge_mid;
        int          n_opts;
        bit          has_ext;
        int          ext_at;
        logic [15:0] ext_len;
        bit          ext_twice;
        bit          fixed_skip;
        int          skip_len;
    } entry_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        end_of_entry = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;
    logic        cfg_wen = 1'b0;
    logic        cfg_index = CFG_ENTRY_MAGIC;
    logic [31:0] cfg_data = '0;

    EntryFieldScoreboard sb = new();

    logic [31:0] magic_now = '0;
    logic [7:0]  ext_tag_now = '0;
    int          next_gap = 0;
    int          bytes_taken = 0;
    int          cycles = 0;
    bit          calm_in = 1'b0;
    bit          calm_out = 1'b0;
    bit          hold_out_req = 1'b0;

    dir_entry_stream_parser_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_entry (end_of_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value        (value),
        .last         (last),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(kind, value, last);
    end

    // Receiver: a random stall before each word, and one long hold on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_out_req)
            begin
                gap = 240;
                hold_out_req = 1'b0;
            end
            else
                gap = calm_out ? 0 : $urandom_range(0, 16);
            if (gap != 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic void put_field(ref logic [7:0] q[$], input logic [63:0] v,
                                      input int n);
        for (int i = n - 1; i >= 0; i--)
            q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_random(ref logic [7:0] q[$], input int n);
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
    endfunction

    function automatic void put_string(ref logic [7:0] q[$], input int n);
        put_field(q, 64'(n), 2);
        put_random(q, n);
    endfunction

    // A wrongly sized extension fails at its length, so only a few body bytes follow.
    function automatic void put_ext(ref logic [7:0] q[$], input logic [15:0] len);
        q.push_back(ext_tag_now);
        put_field(q, {48'd0, len}, 2);
        put_random(q, (len == P9_OPT_LEN) ? 12 : ((len > 16'd4) ? 4 : int'(len)));
    endfunction

    function automatic entry_shape_t base_shape();
        entry_shape_t s;
        s.magic = magic_now;
        s.version = VERSION_NEW;
        s.elem_len = 0;
        s.uid_len = 0;
        s.gid_len = 0;
        s.mid_len = 0;
        s.huge_mid = 1'b0;
        s.n_opts = 0;
        s.has_ext = 1'b0;
        s.ext_at = 0;
        s.ext_len = P9_OPT_LEN;
        s.ext_twice = 1'b0;
        s.fixed_skip = 1'b0;
        s.skip_len = 0;
        return s;
    endfunction

    function automatic entry_shape_t random_shape();
        entry_shape_t s;
        s = base_shape();
        s.version = $urandom_range(0, 1) ? VERSION_OLD : VERSION_NEW;
        s.elem_len = $urandom_range(0, 10);
        s.uid_len = $urandom_range(0, 5);
        s.gid_len = $urandom_range(0, 5);
        s.mid_len = $urandom_range(0, 5);
        s.n_opts = $urandom_range(0, 3);
        s.has_ext = ($urandom_range(0, 2) != 0);
        s.ext_at = $urandom_range(0, s.n_opts);
        return s;
    endfunction

    function automatic void build_entry(ref logic [7:0] q[$], input entry_shape_t s);
        logic [7:0] tag;
        int         len;
        put_field(q, {32'd0, s.magic}, 4);
        put_field(q, {48'd0, s.version}, 2);
        put_string(q, s.elem_len);
        put_random(q, 4 + 8);
        if (s.version == VERSION_OLD)
            put_random(q, SCORE_BYTES);
        put_string(q, s.uid_len);
        put_string(q, s.gid_len);
        if (s.huge_mid)
        begin
            // A very long string that the entry never finishes.
            put_field(q, {48'd0, 16'h8000 | 16'($urandom)}, 2);
            put_random(q, $urandom_range(0, 6));
            return;
        end
        put_string(q, s.mid_len);
        put_random(q, 5 * 4);
        for (int i = 0; i <= s.n_opts; i++)
        begin
            if (s.has_ext && i == s.ext_at)
                put_ext(q, s.ext_len);
            if (i < s.n_opts)
            begin
                tag = 8'($urandom);
                if (tag == ext_tag_now)
                    tag ^= 8'h01;
                if (s.fixed_skip)
                    len = s.skip_len;
                else if ($urandom_range(0, 49) == 0)
                    len = $urandom_range(256, 300);
                else
                    len = $urandom_range(0, 5);
                q.push_back(tag);
                put_string(q, len);
            end
        end
        if (s.ext_twice)
            put_ext(q, P9_OPT_LEN);
    endfunction

    // Leaves valid high at the falling edge when the next word follows at once.
    task automatic send_byte(input logic [7:0] b, input logic eoe);
        repeat (next_gap) @(negedge clk);
        in_valid = 1'b1;
        data_byte = b;
        end_of_entry = eoe;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, eoe);
        bytes_taken++;
        @(negedge clk);
        next_gap = calm_in ? 0 : $urandom_range(0, 16);
        if (next_gap != 0)
            in_valid = 1'b0;
    endtask

    task automatic send_entry(ref logic [7:0] q[$]);
        calm_in = ($urandom_range(0, 4) == 0);
        calm_out = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_shape(input entry_shape_t s, input int keep);
        logic [7:0] q[$];
        build_entry(q, s);
        while (keep > 0 && q.size() > keep)
            void'(q.pop_back());
        send_entry(q);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.waiting() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_regs(input logic [31:0] magic, input logic [7:0] tag);
        drain_results();
        cfg_wen = 1'b1;
        cfg_index = CFG_ENTRY_MAGIC;
        cfg_data = magic;
        @(negedge clk);
        cfg_index = CFG_EXT_TAG;
        cfg_data = {24'd0, tag};
        @(negedge clk);
        cfg_wen = 1'b0;
        sb.set_regs(magic, tag);
        magic_now = magic;
        ext_tag_now = tag;
    endtask

    initial
    begin
        entry_shape_t s;
        logic [7:0]   q[$];
        int           pick;
        int           entries;
        int           k;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_regs(32'h00FF_5AA5, 8'h00);

        // Empty strings, an empty option and the extension.
        s = base_shape();
        s.n_opts = 1;
        s.fixed_skip = 1'b1;
        s.has_ext = 1'b1;
        s.ext_at = 1;
        send_shape(s, 0);
        // Version 7 with the score field, short strings and the extension first.
        s = base_shape();
        s.version = VERSION_OLD;
        s.elem_len = 3;
        s.uid_len = 1;
        s.gid_len = 2;
        s.mid_len = 1;
        s.n_opts = 2;
        s.has_ext = 1'b1;
        send_shape(s, 0);
        // Bad magic; the bytes after it are ignored.
        s = base_shape();
        s.magic = magic_now ^ 32'h8000_0001;
        send_shape(s, 6);
        s = base_shape();
        s.version = VERSION_NEW + 16'd1;
        send_shape(s, 0);
        s = base_shape();
        s.has_ext = 1'b1;
        s.ext_twice = 1'b1;
        send_shape(s, 0);
        s = base_shape();
        s.has_ext = 1'b1;
        s.ext_len = P9_OPT_LEN - 16'd1;
        send_shape(s, 0);
        // Cut off inside the uid string.
        s = base_shape();
        s.uid_len = 4;
        send_shape(s, 25);
        // Ends exactly at the close of the mode word.
        send_shape(base_shape(), 0);
        q.delete();
        q.push_back(8'hFF);
        send_entry(q);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_regs(32'h0000_0000, 8'h00);
                1:       write_regs(32'hFFFF_FFFF, 8'hFF);
                default: write_regs($urandom, 8'($urandom));
            endcase
            if (p == 1)
                hold_out_req = 1'b1;
            bytes_taken = 0;
            entries = 0;
            while (bytes_taken < RANDOM_BYTES / PHASES)
            begin
                if (p == 2 && entries == 3)
                    drain_results();
                entries++;
                pick = $urandom_range(0, 99);
                s = random_shape();
                if (pick < 4)
                    s.magic ^= 32'(1) << $urandom_range(0, 31);
                else if (pick < 8)
                begin
                    do
                        s.version = $urandom_range(0, 1) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 16));
                    while (s.version == VERSION_OLD || s.version == VERSION_NEW);
                end
                else if (pick < 12)
                begin
                    s.has_ext = 1'b1;
                    do
                        s.ext_len = $urandom_range(0, 1) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 20));
                    while (s.ext_len == P9_OPT_LEN);
                end
                else if (pick < 15)
                begin
                    s.has_ext = 1'b1;
                    s.ext_twice = 1'b1;
                end
                else if (pick < 17)
                    s.huge_mid = 1'b1;
                q.delete();
                build_entry(q, s);
                if (pick >= 17 && pick < 27)
                begin
                    k = $urandom_range(1, q.size() - 1);
                    while (q.size() > k)
                        void'(q.pop_back());
                end
                else if (pick >= 27 && pick < 30)
                begin
                    q.delete();
                    put_random(q, $urandom_range(1, 24));
                end
                send_entry(q);
            end
        end

        in_valid = 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
